/* rtl/core/lwd_pkg.sv */
// shared types and constants for the lz77 window decompressor
`timescale 1ns / 1ps

package lwd_pkg;

    // history window geometry
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // output size field from the header and the running byte count
    localparam int SIZE_W  = 24;
    localparam int COUNT_W = SIZE_W + 1;

    // copy length: high nibble plus three, at most eighteen
    localparam int LEN_W     = 5;
    localparam int MIN_MATCH = 3;

    // tokens governed by one flag byte
    localparam int TOKENS_PER_FLAG = 8;
    localparam int TOK_W           = 4;

    // parse phases of the compressed stream
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_FLAG   = 2'd1;
    localparam logic [1:0] PH_TOKEN  = 2'd2;
    localparam logic [1:0] PH_REF2   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;     // capture the accepted input word
        logic parse;       // header, flag or first reference byte
        logic emit_lit;    // write the literal out
        logic start_copy;  // set up length and distance of a reference
        logic issue_rd;    // read the window for the next copied byte
        logic emit_copy;   // write the copied byte out
    } lwd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] phase;      // current parse phase
        logic       ref_bit;    // flag bit of the current token
        logic       slot_free;  // output register can take a word
        logic       copy_last;  // the pending copied byte is the final one
    } lwd_status_t;

endpackage

/* rtl/core/lwd_coded_if.sv */
// stream interfaces for compressed input words and decoded output words
`timescale 1ns / 1ps

interface lwd_coded_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lwd_decoded_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    output ready);
endinterface

/* rtl/core/lwd_ctrl.sv */
// controller state machine sequencing decode and window copies
`timescale 1ns / 1ps

module lwd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lwd_pkg::lwd_status_t status,
    output lwd_pkg::lwd_cmd_t    cmd
);
    import lwd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                if (status.phase == PH_REF2)
                begin
                    cmd.start_copy = 1'b1;
                    state_next     = S_RD;
                end
                else if (status.phase == PH_TOKEN && !status.ref_bit)
                begin
                    // literal waits for room in the output register
                    if (status.slot_free)
                    begin
                        cmd.emit_lit = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.parse  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.issue_rd = 1'b1;
                state_next   = S_WR;
            end
            S_WR:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_copy = 1'b1;
                    state_next    = status.copy_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/lwd_datapath.sv */
// parse registers, history window memory and output register
`timescale 1ns / 1ps

module lwd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  lwd_pkg::lwd_cmd_t    cmd,
    output lwd_pkg::lwd_status_t status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                stream_done
);
    import lwd_pkg::*;

    // history window
    logic [7:0]         hist_mem [HIST_DEPTH];

    logic [7:0]         in_reg;
    logic [1:0]         phase_reg,   phase_next;
    logic [1:0]         hdr_idx_reg, hdr_idx_next;
    logic [SIZE_W-1:0]  size_reg,    size_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [7:0]         flags_reg,   flags_next;
    logic [TOK_W-1:0]   tok_reg,     tok_next;
    logic [7:0]         first_reg,   first_next;
    logic [HIST_AW-1:0] wp_reg,      wp_next;
    logic               wrapped_reg, wrapped_next;
    logic               out_valid_reg, out_valid_next;

    logic [HIST_AW-1:0] dist_reg;
    logic [LEN_W-1:0]   left_reg;
    logic [7:0]         rdata_reg;
    logic               rd_zero_reg;
    logic [7:0]         out_byte_reg;
    logic               run_last_reg;
    logic               done_reg;

    logic               emit;
    logic [7:0]         emit_data;
    logic [COUNT_W-1:0] count_inc;
    logic               reached;
    logic               end_tok;
    logic [TOK_W-1:0]   tok_inc;
    logic [SIZE_W-1:0]  size_full;
    logic [HIST_AW-1:0] rd_addr;

    // shared emit path
    assign emit      = cmd.emit_lit || cmd.emit_copy;
    assign emit_data = cmd.emit_lit ? in_reg : (rd_zero_reg ? 8'h00 : rdata_reg);
    assign count_inc = count_reg + COUNT_W'(1);
    assign reached   = count_inc >= {1'b0, size_reg};
    assign end_tok   = cmd.emit_lit || (cmd.emit_copy && left_reg == LEN_W'(1));
    assign tok_inc   = tok_reg + TOK_W'(1);
    assign size_full = size_reg | {in_reg, 16'h0000};
    assign rd_addr   = wp_reg - dist_reg;

    // status to the controller
    assign status.phase     = phase_reg;
    assign status.ref_bit   = flags_reg[3'd7 - tok_reg[2:0]];
    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.copy_last = left_reg == LEN_W'(1);

    // parse state update
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        size_next      = size_reg;
        count_next     = count_reg;
        flags_next     = flags_reg;
        tok_next       = tok_reg;
        first_next     = first_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;

        if (cmd.parse)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    case (hdr_idx_reg)
                        2'd0:
                        begin
                            size_next    = '0;
                            hdr_idx_next = 2'd1;
                        end
                        2'd1:
                        begin
                            size_next    = size_reg | {16'h0000, in_reg};
                            hdr_idx_next = 2'd2;
                        end
                        2'd2:
                        begin
                            size_next    = size_reg | {8'h00, in_reg, 8'h00};
                            hdr_idx_next = 2'd3;
                        end
                        default:
                        begin
                            // last header byte: a zero size starts over at a new header
                            size_next    = size_full;
                            count_next   = '0;
                            hdr_idx_next = 2'd0;
                            phase_next   = (size_full == '0) ? PH_HEADER : PH_FLAG;
                        end
                    endcase
                end
                PH_FLAG:
                begin
                    flags_next = in_reg;
                    tok_next   = '0;
                    phase_next = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    first_next = in_reg;
                    phase_next = PH_REF2;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (emit)
        begin
            wp_next        = wp_reg + HIST_AW'(1);
            wrapped_next   = wrapped_reg || (wp_reg == '1);
            count_next     = count_inc;
            out_valid_next = 1'b1;
        end

        // end of token: stream end drops any remaining flag bits
        if (end_tok)
        begin
            tok_next = tok_inc;
            if (reached)
            begin
                phase_next   = PH_HEADER;
                hdr_idx_next = 2'd0;
            end
            else if (tok_inc >= TOK_W'(TOKENS_PER_FLAG))
            begin
                phase_next = PH_FLAG;
            end
            else
            begin
                phase_next = PH_TOKEN;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            size_reg      <= '0;
            count_reg     <= '0;
            flags_reg     <= '0;
            tok_reg       <= '0;
            first_reg     <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            size_reg      <= size_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            tok_reg       <= tok_next;
            first_reg     <= first_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_byte;
        end
        if (cmd.start_copy)
        begin
            left_reg <= LEN_W'(first_reg[7:4]) + LEN_W'(MIN_MATCH);
            dist_reg <= {first_reg[3:0], in_reg} + HIST_AW'(1);
        end
        else if (cmd.emit_copy)
        begin
            left_reg <= left_reg - LEN_W'(1);
        end
        if (emit)
        begin
            out_byte_reg <= emit_data;
            run_last_reg <= end_tok;
            done_reg     <= reached;
        end
    end

    // window write
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            hist_mem[wp_reg] <= emit_data;
        end
    end

    // window read; entries not yet written since reset read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.issue_rd)
        begin
            rdata_reg   <= hist_mem[rd_addr];
            rd_zero_reg <= !wrapped_reg && (rd_addr >= wp_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_done = done_reg;

endmodule

/* rtl/core/lz77_window_decompressor.sv */
// top level of the lz77 window decompressor
`timescale 1ns / 1ps

// Decodes a type 0x10 lz77 stream, one compressed word in and one decoded word out per
// handshake. A header, flag or first reference word is accepted and then decoded; a
// literal is accepted and then written out after any wait for the output register; the
// second word of a reference starts a copy of 3 to 18 bytes, each needing a read of the
// 4096-byte window, whose read data is registered, followed by its write back and output.
// The window needs no clearing pass after reset: it fills in order from address zero, so
// entries at or beyond the write pointer before its first wrap read as zero. run_last
// marks the final word caused by one input word, stream_done every word at or past the
// header size. The output register holds a finished word while the next input is taken.
module lz77_window_decompressor (
    input  logic          clk,
    input  logic          rst_n,
    lwd_coded_if.sink     coded,
    lwd_decoded_if.source decoded
);
    import lwd_pkg::*;

    lwd_cmd_t    cmd;
    lwd_status_t status;

    // controller
    lwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (coded.valid),
        .in_ready (coded.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    lwd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (coded.in_byte),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (decoded.ready),
        .out_valid   (decoded.valid),
        .out_byte    (decoded.out_byte),
        .run_last    (decoded.run_last),
        .stream_done (decoded.stream_done)
    );

`ifndef SYNTHESIS
    // an output word is only produced when the output register has room
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_lit || cmd.emit_copy) |-> status.slot_free)
        else $error("output word produced with no room in the output register");

    // one input word is decoded before the next is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (coded.valid && coded.ready) |=> !coded.ready)
        else $error("input taken while the previous word is still decoding");

    // a window read is always followed by its write cycle
    a_read_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_rd |=> !cmd.issue_rd && !coded.ready)
        else $error("window read not followed by its write cycle");
`endif

endmodule
